[rtl/dpff_pkg.sv]
// Package for the dual priority frame FIFO.
// Holds sizing constants, status codes, the item structs and address helpers.
// No dependencies.
package dpff_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int FRAME_BYTES = 11;

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = 2 * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int MOD_W     = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W     = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int LEN_W     = 8;
  localparam int FIT_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_POP_ERR = 2'd2;
  localparam logic [1:0] ST_DROP    = 2'd3;

  typedef struct packed {
    logic             op;
    logic             queue_sel;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] block_len;
    logic             block_first;
    logic             block_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       from_queue;
    logic       last;
  } out_item_t;

  // Result flags from the controller to the output stage.
  typedef struct packed {
    logic       res_valid;
    logic [1:0] res_status;
    logic       res_queue;
    logic       rd_valid;
    logic       rd_last;
    logic       rd_queue;
  } ctl_res_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic q, input logic [PTR_W-1:0] p);
    logic [ADDR_W-1:0] a;
    if (q) begin
      a = ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    end else begin
      a = ADDR_W'(p);
    end
    return a;
  endfunction

endpackage

[rtl/dpff_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dpff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dpff_ctrl.sv]
// Queue controller: pointers, fill counts, block locks and the pop sequencer.
// Drives the byte store RAM ports. Depends on dpff_pkg.
module dpff_ctrl import dpff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_item_t          in_item,
  output logic              busy,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [7:0]        mem_wdata,
  output logic              mem_re,
  output logic [ADDR_W-1:0] mem_raddr,
  output ctl_res_t          ctl_res
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic             state_r, state_nxt;
  logic [PTR_W-1:0] rp_r   [2];
  logic [PTR_W-1:0] rp_nxt [2];
  logic [PTR_W-1:0] wp_r   [2];
  logic [PTR_W-1:0] wp_nxt [2];
  logic [CNT_W-1:0] cnt_r  [2];
  logic [CNT_W-1:0] cnt_nxt[2];
  logic [MOD_W-1:0] mod_r  [2];   // fill count modulo frame size
  logic [MOD_W-1:0] mod_nxt[2];
  logic [1:0]       lock_r, lock_nxt;
  logic             acc_r, acc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pq_r, pq_nxt;
  logic             res_v_r, res_v_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic             res_q_r, res_q_nxt;
  logic             rd_v_r, rd_v_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             rd_q_r, rd_q_nxt;

  logic             accept;
  logic             q;
  logic             fits;
  logic             acc_e;
  logic [1:0]       lock_e;
  logic             store;
  logic             pop_q;
  logic             pop_last;

  assign busy   = (state_r == ST_POP);
  assign accept = start && !busy;
  assign q      = in_item.queue_sel;
  assign fits   = (FIT_W'(cnt_r[q]) + FIT_W'(in_item.block_len)) <= FIT_W'(QUEUE_DEPTH);
  assign pop_q  = (cnt_r[0] != '0) ? 1'b0 : 1'b1;
  assign pop_last = (idx_r == IDX_W'(FRAME_BYTES - 1));

  always_comb begin
    state_nxt   = state_r;
    rp_nxt      = rp_r;
    wp_nxt      = wp_r;
    cnt_nxt     = cnt_r;
    mod_nxt     = mod_r;
    lock_nxt    = lock_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;
    pq_nxt      = pq_r;
    res_v_nxt   = 1'b0;
    res_st_nxt  = res_st_r;
    res_q_nxt   = res_q_r;
    rd_v_nxt    = 1'b0;
    rd_last_nxt = rd_last_r;
    rd_q_nxt    = rd_q_r;
    mem_we      = 1'b0;
    mem_waddr   = mem_addr(q, wp_r[q]);
    mem_wdata   = in_item.data_byte;
    mem_re      = 1'b0;
    mem_raddr   = mem_addr(pq_r, rp_r[pq_r]);

    // a new first byte abandons any open block before the fit test
    acc_e  = in_item.block_first ? fits : acc_r;
    lock_e = lock_r;
    if (in_item.block_first) begin
      lock_e    = 2'b00;
      lock_e[q] = fits;
    end
    store = acc_e && lock_e[q] && (cnt_r[q] < CNT_W'(QUEUE_DEPTH));

    if (state_r == ST_POP) begin
      // one read per cycle; writes are held off by busy
      mem_re          = 1'b1;
      rp_nxt[pq_r]    = ring_next(rp_r[pq_r]);
      cnt_nxt[pq_r]   = cnt_r[pq_r] - CNT_W'(1);
      rd_v_nxt        = 1'b1;
      rd_last_nxt     = pop_last;
      rd_q_nxt        = pq_r;
      idx_nxt         = idx_r + IDX_W'(1);
      if (pop_last) begin
        state_nxt = ST_IDLE;
      end
    end else if (accept) begin
      if (in_item.op == OP_PUSH) begin
        res_v_nxt  = 1'b1;
        res_q_nxt  = 1'b0;
        res_st_nxt = store ? ST_OK : ST_DROP;
        if (store) begin
          mem_we     = 1'b1;
          wp_nxt[q]  = ring_next(wp_r[q]);
          cnt_nxt[q] = cnt_r[q] + CNT_W'(1);
          if (mod_r[q] == MOD_W'(FRAME_BYTES - 1)) begin
            mod_nxt[q] = '0;
          end else begin
            mod_nxt[q] = mod_r[q] + MOD_W'(1);
          end
        end
        if (in_item.block_last) begin
          lock_nxt = 2'b00;
          acc_nxt  = 1'b0;
        end else begin
          lock_nxt = lock_e;
          acc_nxt  = acc_e;
        end
      end else begin
        if ((cnt_r[0] == '0) && (cnt_r[1] == '0)) begin
          res_v_nxt  = 1'b1;
          res_st_nxt = ST_EMPTY;
          res_q_nxt  = 1'b0;
        end else if (lock_r[pop_q] || (mod_r[pop_q] != '0)) begin
          res_v_nxt  = 1'b1;
          res_st_nxt = ST_POP_ERR;
          res_q_nxt  = pop_q;
        end else begin
          state_nxt = ST_POP;
          pq_nxt    = pop_q;
          idx_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rp_r    <= '{default: '0};
      wp_r    <= '{default: '0};
      cnt_r   <= '{default: '0};
      mod_r   <= '{default: '0};
      lock_r  <= 2'b00;
      acc_r   <= 1'b0;
      idx_r   <= '0;
      pq_r    <= 1'b0;
      res_v_r <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      mod_r   <= mod_nxt;
      lock_r  <= lock_nxt;
      acc_r   <= acc_nxt;
      idx_r   <= idx_nxt;
      pq_r    <= pq_nxt;
      res_v_r <= res_v_nxt;
      rd_v_r  <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_st_r  <= res_st_nxt;
    res_q_r   <= res_q_nxt;
    rd_last_r <= rd_last_nxt;
    rd_q_r    <= rd_q_nxt;
  end

  assign ctl_res.res_valid  = res_v_r;
  assign ctl_res.res_status = res_st_r;
  assign ctl_res.res_queue  = res_q_r;
  assign ctl_res.rd_valid   = rd_v_r;
  assign ctl_res.rd_last    = rd_last_r;
  assign ctl_res.rd_queue   = rd_q_r;

`ifndef NO_ASSERTIONS
  a_no_write_in_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> !mem_we)
    else $error("RAM write during frame pop");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(QUEUE_DEPTH)) && (cnt_r[1] <= CNT_W'(QUEUE_DEPTH)))
    else $error("fill count above queue depth");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_v_r && rd_v_r))
    else $error("status result and frame byte in the same cycle");

  a_pop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && pop_last) |=> (state_r == ST_IDLE && rd_v_r && rd_last_r))
    else $error("frame pop did not end after its last byte");
`endif

endmodule

[rtl/dual_priority_frame_fifo_top.sv]
// Two byte queues with block-reserved push and framed pop, priority to queue 0.
// Instantiates dpff_ctrl and dpff_ram; depends on dpff_pkg.
//
// Usage: an item transfers on a clock edge with start high and busy low. A push's
// single result strobes on out_valid in the next cycle and another item may follow
// at once. A pop that reports empty or an error likewise leaves busy low. A pop that
// streams a frame holds busy while it reads FRAME_BYTES (11) bytes, one byte per
// cycle through the byte store's single read port; each byte strobes on out_valid
// in the cycle after its read, the last one flagged. Results cannot be stalled:
// capture every out_valid cycle.
module dual_priority_frame_fifo_top import dpff_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;
  ctl_res_t          ctl_res;

  dpff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .ctl_res   (ctl_res)
  );

  dpff_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // frame bytes come straight off the RAM output register
  always_comb begin
    out_valid = ctl_res.res_valid || ctl_res.rd_valid;
    if (ctl_res.rd_valid) begin
      out_item.status     = ST_OK;
      out_item.out_byte   = mem_rdata;
      out_item.from_queue = ctl_res.rd_queue;
      out_item.last       = ctl_res.rd_last;
    end else begin
      out_item.status     = ctl_res.res_status;
      out_item.out_byte   = 8'd0;
      out_item.from_queue = ctl_res.res_queue;
      out_item.last       = 1'b1;
    end
  end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for dual_priority_frame_fifo_top.
// Keeps a shadow copy of both byte queues to predict every result and checks the
// result strobes against it. Depends on dpff_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb;
  import dpff_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int IN_W           = $bits(in_item_t);

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  dual_priority_frame_fifo_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Shadow queue state.
  logic [7:0] shadow_bytes [2][QUEUE_DEPTH];
  int         rd_pos [2];
  int         wr_pos [2];
  int         fill   [2];
  bit         wr_lock [2];
  bit         blk_open;

  out_item_t  awaited_results [$];
  int         err_count;
  int         items_sent;
  int         idle_pct;
  int         stall_cycles;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic void clear_shadow();
    for (int q = 0; q < 2; q++) begin
      rd_pos[q]  = 0;
      wr_pos[q]  = 0;
      fill[q]    = 0;
      wr_lock[q] = 1'b0;
    end
    blk_open = 1'b0;
  endfunction

  function automatic void queue_result(logic [1:0] st, logic [7:0] b, logic q, logic lst);
    out_item_t r;
    r.status     = st;
    r.out_byte   = b;
    r.from_queue = q;
    r.last       = lst;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_fifo_item(input in_item_t it);
    int q;
    bit stored;
    if (it.op == OP_PUSH) begin
      q = int'(it.queue_sel);
      stored = 1'b0;
      if (it.block_first) begin
        // a new first byte abandons any open block
        wr_lock[0] = 1'b0;
        wr_lock[1] = 1'b0;
        blk_open   = 1'b0;
        if (fill[q] + int'(it.block_len) <= QUEUE_DEPTH) begin
          blk_open   = 1'b1;
          wr_lock[q] = 1'b1;
        end
      end
      if (blk_open && wr_lock[q] && fill[q] < QUEUE_DEPTH) begin
        shadow_bytes[q][wr_pos[q]] = it.data_byte;
        wr_pos[q] = (wr_pos[q] == QUEUE_DEPTH - 1) ? 0 : wr_pos[q] + 1;
        fill[q]++;
        stored = 1'b1;
      end
      if (it.block_last) begin
        wr_lock[0] = 1'b0;
        wr_lock[1] = 1'b0;
        blk_open   = 1'b0;
      end
      queue_result(stored ? ST_OK : ST_DROP, 8'h00, 1'b0, 1'b1);
    end else begin
      if (fill[0] != 0) begin
        q = 0;
      end else if (fill[1] != 0) begin
        q = 1;
      end else begin
        queue_result(ST_EMPTY, 8'h00, 1'b0, 1'b1);
        return;
      end
      if (wr_lock[q] || (fill[q] % FRAME_BYTES) != 0) begin
        queue_result(ST_POP_ERR, 8'h00, q[0], 1'b1);
      end else begin
        for (int i = 0; i < FRAME_BYTES; i++) begin
          queue_result(ST_OK, shadow_bytes[q][rd_pos[q]], q[0], i == FRAME_BYTES - 1);
          rd_pos[q] = (rd_pos[q] == QUEUE_DEPTH - 1) ? 0 : rd_pos[q] + 1;
          fill[q]--;
        end
      end
    end
  endfunction

  function automatic in_item_t push_byte(bit q, logic [7:0] d, logic [7:0] len,
                                         bit first, bit lst);
    in_item_t it;
    it.op          = OP_PUSH;
    it.queue_sel   = q;
    it.data_byte   = d;
    it.block_len   = len;
    it.block_first = first;
    it.block_last  = lst;
    return it;
  endfunction

  // Pop with random don't-care fields.
  function automatic in_item_t pop_item();
    in_item_t it;
    it = in_item_t'(IN_W'($urandom));
    it.op = OP_POP;
    return it;
  endfunction

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < 2) begin
      wait_drained();
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_fifo_item(it);
    items_sent++;
  endtask

  task automatic push_block(bit q, int nbytes, logic [7:0] len, bit omit_last);
    for (int i = 0; i < nbytes; i++) begin
      send_item(push_byte(q, 8'($urandom), len, i == 0,
                          (i == nbytes - 1) && !omit_last));
    end
  endtask

  // Top a queue up to a whole number of frames and close any open block.
  task automatic repair_queue(bit q);
    int need;
    need = (FRAME_BYTES - (fill[q] % FRAME_BYTES)) % FRAME_BYTES;
    if (need == 0) begin
      push_block(q, FRAME_BYTES, 8'(FRAME_BYTES), 1'b0);
    end else begin
      push_block(q, need, 8'd0, 1'b0);
    end
  endtask

  task automatic test_empty_pop();
    send_item(pop_item());
  endtask

  task automatic test_frame_roundtrip();
    send_item(push_byte(1'b1, 8'h00, 8'(FRAME_BYTES), 1'b1, 1'b0));
    send_item(push_byte(1'b1, 8'hFF, 8'(FRAME_BYTES), 1'b0, 1'b0));
    for (int i = 2; i < FRAME_BYTES; i++) begin
      send_item(push_byte(1'b1, 8'($urandom), 8'($urandom), 1'b0,
                          i == FRAME_BYTES - 1));
    end
    wait_drained();
    // queue 0 empty, so the frame comes from queue 1
    send_item(pop_item());
  endtask

  task automatic test_locked_pop();
    send_item(push_byte(1'b0, 8'hA5, 8'd255, 1'b1, 1'b0));
    send_item(pop_item());
    // new first byte abandons the open block; zero length always fits
    send_item(push_byte(1'b0, 8'h5A, 8'd0, 1'b1, 1'b0));
    send_item(push_byte(1'b1, 8'h3C, 8'd0, 1'b0, 1'b0));
    send_item(push_byte(1'b0, 8'hC3, 8'd0, 1'b0, 1'b1));
    // three bytes held: partial frame
    send_item(pop_item());
  endtask

  task automatic test_rejected_block();
    send_item(push_byte(1'b0, 8'h11, 8'd254, 1'b1, 1'b0));
    send_item(push_byte(1'b0, 8'h22, 8'd254, 1'b0, 1'b0));
    send_item(push_byte(1'b0, 8'h33, 8'd254, 1'b0, 1'b1));
    // stray byte with no open block
    send_item(push_byte(1'b1, 8'h44, 8'd1, 1'b0, 1'b0));
    // single byte block, first and last together
    send_item(push_byte(1'b0, 8'h55, 8'd1, 1'b1, 1'b1));
  endtask

  task automatic test_random_traffic(int idle, int n_items);
    int base;
    int r;
    int n;
    logic [7:0] len;
    base = items_sent;
    idle_pct = idle;
    while (items_sent - base < n_items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        r = $urandom_range(99);
        if (r < 70) begin
          n   = FRAME_BYTES * $urandom_range(1, 2);
          len = 8'(n);
        end else if (r < 85) begin
          n   = $urandom_range(1, 30);
          len = 8'(n);
        end else begin
          n   = $urandom_range(1, 30);
          len = 8'($urandom_range(255));
        end
        push_block(1'($urandom), n, len, $urandom_range(99) < 5);
      end else if (r < 75) begin
        send_item(pop_item());
      end else if (r < 85) begin
        repair_queue(fill[0] != 0 ? 1'b0 : 1'b1);
      end else begin
        send_item(in_item_t'(IN_W'($urandom)));
      end
    end
  endtask

  // Blocks one byte over the free room, then exactly as long, if room < 255.
  task automatic test_fit_boundary();
    bit q;
    int room;
    idle_pct = 0;
    q = (fill[1] >= fill[0]) ? 1'b1 : 1'b0;
    if (fill[q] < 2) begin
      push_block(q, 2, 8'd2, 1'b0);
    end
    room = QUEUE_DEPTH - fill[q];
    if (room < 255) begin
      push_block(q, 2, 8'(room + 1), 1'b0);
      push_block(q, 2, 8'(room), 1'b0);
    end
    send_item(pop_item());
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d byte %0h", out_item.status, out_item.out_byte);
        err_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          err_count++;
        end
        if (out_item.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_item.out_byte);
          err_count++;
        end
        if (out_item.from_queue !== want.from_queue) begin
          $error("from_queue: expected %0d, got %0d", want.from_queue, out_item.from_queue);
          err_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_item.last);
          err_count++;
        end
      end
    end
  end

  // Cycles without any transfer in either direction.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    err_count    = 0;
    items_sent   = 0;
    idle_pct     = 0;
    stall_cycles = 0;
    clear_shadow();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_pop();
    test_frame_roundtrip();
    test_locked_pop();
    test_rejected_block();
    test_random_traffic(22, 25);
    test_random_traffic(60, 25);
    test_random_traffic(0, 20);
    test_fit_boundary();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
